/* hw/rtl/line_path_stepper_assert.svh */
// ----------------------------------------------------------------------------
// Line path stepper assertion macros
// Shared concurrent assertion forms for the stepper modules. Each use expects
// a clock named clk and a synchronous reset named rst in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef LINE_PATH_STEPPER_ASSERT_SVH
`define LINE_PATH_STEPPER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/lps_pkg.sv */
// ----------------------------------------------------------------------------
// Line path stepper package
// Shared constants, codes and control types of the line path stepper.
// ----------------------------------------------------------------------------
package lps_pkg;

  // Default geometry of the walk.
  localparam int COORD_BITS_DEF     = 12;
  localparam int STEPS_PER_TILE_DEF = 15;

  // Tile coordinates are reported in a fixed field width.
  localparam int TILE_BITS = 9;

  // Word kinds on the input channel.
  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_TICK = 1'b1
  } mode_t;

  // Control from the pipeline to the step core.
  typedef struct packed {
    logic fire;  // a word leaves the input stage this cycle
    logic tick;  // the word advances the walk instead of loading a path
  } step_ctrl_t;

endpackage

/* hw/rtl/lps_tile_div.sv */
// ----------------------------------------------------------------------------
// Tile divider
// Divides a coordinate by the constant sub-steps per tile using a multiply by
// a rounded-up reciprocal and a shift, which is exact for every coordinate.
// ----------------------------------------------------------------------------
module lps_tile_div #(
  parameter int COORD_BITS     = lps_pkg::COORD_BITS_DEF,
  parameter int STEPS_PER_TILE = lps_pkg::STEPS_PER_TILE_DEF
) (
  input  logic [COORD_BITS-1:0]          coord,
  output logic [lps_pkg::TILE_BITS-1:0]  tile
);

  // Six extra fraction bits cover every divisor up to 64.
  localparam int SHIFT     = COORD_BITS + 6;
  localparam int MULT_BITS = SHIFT + 1;
  localparam int PROD_BITS = COORD_BITS + MULT_BITS;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + STEPS_PER_TILE - 1) / STEPS_PER_TILE;
  localparam logic [MULT_BITS-1:0] RECIP = RECIP_L[MULT_BITS-1:0];

  logic [PROD_BITS-1:0] prod;

  // The quotient is the upper part of the product; the tile field keeps its low bits.
  assign prod = PROD_BITS'(coord) * PROD_BITS'(RECIP);
  assign tile = prod[SHIFT +: lps_pkg::TILE_BITS];

endmodule

/* hw/rtl/lps_step_core.sv */
// ----------------------------------------------------------------------------
// Step core
// Holds the walk state and computes one load or one Bresenham tick per cycle.
// ----------------------------------------------------------------------------
`include "line_path_stepper_assert.svh"

module lps_step_core #(
  parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  lps_pkg::step_ctrl_t ctrl,
  input  logic [COORD_BITS-1:0] src_x,
  input  logic [COORD_BITS-1:0] src_y,
  input  logic [COORD_BITS-1:0] dst_x,
  input  logic [COORD_BITS-1:0] dst_y,
  output logic [COORD_BITS-1:0] res_pos_x,
  output logic [COORD_BITS-1:0] res_pos_y,
  output logic                res_at_dest
);

  localparam int DELTA_BITS = COORD_BITS + 2;
  localparam int ERR_BITS   = COORD_BITS + 4;
  localparam int SUM_BITS   = DELTA_BITS + 1;

  // Walk state.
  logic [COORD_BITS-1:0]        position_x, position_y, target_x, target_y;
  logic signed [DELTA_BITS-1:0] remaining_dx, remaining_dy;
  logic signed [ERR_BITS-1:0]   error_term;
  logic                         major_is_y;

  logic [COORD_BITS-1:0]        position_x_next, position_y_next;
  logic [COORD_BITS-1:0]        target_x_next, target_y_next;
  logic signed [DELTA_BITS-1:0] remaining_dx_next, remaining_dy_next;
  logic signed [ERR_BITS-1:0]   error_term_next;
  logic                         major_is_y_next;

  // Load terms.
  logic [COORD_BITS-1:0]      abs_dx, abs_dy;
  logic signed [ERR_BITS-1:0] load_ex, load_ey, load_err;
  logic                       load_at_dest;

  // Tick terms.
  logic signed [SUM_BITS-1:0] cur_sum;
  logic                       arrived;
  logic signed [ERR_BITS-1:0] ext_dx, ext_dy, err_inc, err_stepped;
  logic                       minor_step;

  // Move one unit toward the target, or stay when already there.
  function automatic logic [COORD_BITS-1:0] toward(input logic [COORD_BITS-1:0] p,
                                                   input logic [COORD_BITS-1:0] t);
    logic [COORD_BITS-1:0] r;
    if (p < t) begin
      r = p + 1'b1;
    end else if (p > t) begin
      r = p - 1'b1;
    end else begin
      r = p;
    end
    return r;
  endfunction

  // Absolute deltas and the initial error term of a new path.
  always_comb begin
    abs_dx  = (src_x > dst_x) ? (src_x - dst_x) : (dst_x - src_x);
    abs_dy  = (src_y > dst_y) ? (src_y - dst_y) : (dst_y - src_y);
    load_ex = signed'(ERR_BITS'(abs_dx));
    load_ey = signed'(ERR_BITS'(abs_dy));
    if (abs_dx < abs_dy) begin
      load_err = (load_ex <<< 1) - load_ey;
    end else if (abs_dy < abs_dx) begin
      load_err = (load_ey <<< 1) - load_ex;
    end else begin
      load_err = '0;
    end
    load_at_dest = (abs_dx == '0) && (abs_dy == '0);
  end

  // Remaining distance test and the error update of one tick.
  always_comb begin
    cur_sum = SUM_BITS'(remaining_dx) + SUM_BITS'(remaining_dy);
    arrived = cur_sum[SUM_BITS-1] || (cur_sum == '0);
    ext_dx  = ERR_BITS'(remaining_dx);
    ext_dy  = ERR_BITS'(remaining_dy);
    if (major_is_y) begin
      err_inc = error_term[ERR_BITS-1] ? (ext_dx <<< 1) : ((ext_dx - ext_dy) <<< 1);
    end else begin
      err_inc = error_term[ERR_BITS-1] ? (ext_dy <<< 1) : ((ext_dy - ext_dx) <<< 1);
    end
    err_stepped = error_term + err_inc;
    minor_step  = !err_stepped[ERR_BITS-1];
  end

  // Next state of the walk.
  always_comb begin
    position_x_next   = position_x;
    position_y_next   = position_y;
    target_x_next     = target_x;
    target_y_next     = target_y;
    remaining_dx_next = remaining_dx;
    remaining_dy_next = remaining_dy;
    error_term_next   = error_term;
    major_is_y_next   = major_is_y;
    res_at_dest       = arrived;
    if (ctrl.tick) begin
      if (!arrived) begin
        res_at_dest     = 1'b0;
        error_term_next = err_stepped;
        if (major_is_y) begin
          remaining_dy_next = remaining_dy - 1'b1;
          position_y_next   = toward(position_y, target_y);
          if (minor_step) begin
            remaining_dx_next = remaining_dx - 1'b1;
            position_x_next   = toward(position_x, target_x);
          end
        end else begin
          remaining_dx_next = remaining_dx - 1'b1;
          position_x_next   = toward(position_x, target_x);
          if (minor_step) begin
            remaining_dy_next = remaining_dy - 1'b1;
            position_y_next   = toward(position_y, target_y);
          end
        end
      end
    end else begin
      position_x_next   = src_x;
      position_y_next   = src_y;
      target_x_next     = dst_x;
      target_y_next     = dst_y;
      remaining_dx_next = signed'({2'b00, abs_dx});
      remaining_dy_next = signed'({2'b00, abs_dy});
      error_term_next   = load_err;
      major_is_y_next   = abs_dx < abs_dy;
      res_at_dest       = load_at_dest;
    end
  end

  assign res_pos_x = position_x_next;
  assign res_pos_y = position_y_next;

  // State registers advance only when a word is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      position_x   <= '0;
      position_y   <= '0;
      target_x     <= '0;
      target_y     <= '0;
      remaining_dx <= '0;
      remaining_dy <= '0;
      error_term   <= '0;
      major_is_y   <= 1'b0;
    end else if (ctrl.fire) begin
      position_x   <= position_x_next;
      position_y   <= position_y_next;
      target_x     <= target_x_next;
      target_y     <= target_y_next;
      remaining_dx <= remaining_dx_next;
      remaining_dy <= remaining_dy_next;
      error_term   <= error_term_next;
      major_is_y   <= major_is_y_next;
    end
  end

  // A load picks y as the major axis exactly when its delta is the larger one.
  `LPS_ASSERT_NEXT(a_load_major, ctrl.fire && !ctrl.tick, major_is_y == (remaining_dy > remaining_dx), "load chose the wrong major axis")

  // A tick that finds the walk finished leaves the position alone.
  `LPS_ASSERT_NEXT(a_arrived_holds, ctrl.fire && ctrl.tick && arrived, $stable(position_x) && $stable(position_y), "finished walk moved")

endmodule

/* hw/rtl/line_path_stepper.sv */
// An accepted word passes the input, step and output registers in order.
// Throughput: one word per cycle unless stalled; the walk state is updated
// combinationally from its own registers; the tile divide has its own stage.
// Reset clears the walk state to zero and empties all pipeline stages.
// ----------------------------------------------------------------------------
// Line path stepper
// Walks a point toward a destination one sub-tile step per tick word and
// reports the position, its tile coordinates and the arrival flag.
// ----------------------------------------------------------------------------
`include "line_path_stepper_assert.svh"

module line_path_stepper #(
  parameter int COORD_BITS     = lps_pkg::COORD_BITS_DEF,
  parameter int STEPS_PER_TILE = lps_pkg::STEPS_PER_TILE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          mode,
  input  logic [COORD_BITS-1:0]         src_x,
  input  logic [COORD_BITS-1:0]         src_y,
  input  logic [COORD_BITS-1:0]         dst_x,
  input  logic [COORD_BITS-1:0]         dst_y,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [COORD_BITS-1:0]         pos_x,
  output logic [COORD_BITS-1:0]         pos_y,
  output logic [lps_pkg::TILE_BITS-1:0] tile_x,
  output logic [lps_pkg::TILE_BITS-1:0] tile_y,
  output logic                          at_destination
);

  // Input stage.
  logic                  a_vld;
  logic                  a_mode;
  logic [COORD_BITS-1:0] a_src_x, a_src_y, a_dst_x, a_dst_y;

  // Step stage.
  logic                  b_vld;
  logic [COORD_BITS-1:0] b_pos_x, b_pos_y;
  logic                  b_at_dest;

  logic                  accept, en_b, en_c;
  lps_pkg::step_ctrl_t   ctrl;
  logic [COORD_BITS-1:0] step_pos_x, step_pos_y;
  logic                  step_at_dest;
  logic [lps_pkg::TILE_BITS-1:0] div_tile_x, div_tile_y;

  // Stage enables: each stage moves when the one after it is empty or moving.
  assign en_c       = b_vld && (!result_valid || !result_stall);
  assign en_b       = a_vld && (!b_vld || en_c);
  assign item_stall = a_vld && !en_b;
  assign accept     = item_valid && !item_stall;

  assign ctrl.fire = en_b;
  assign ctrl.tick = (a_mode == lps_pkg::MODE_TICK);

  lps_step_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .src_x       (a_src_x),
    .src_y       (a_src_y),
    .dst_x       (a_dst_x),
    .dst_y       (a_dst_y),
    .res_pos_x   (step_pos_x),
    .res_pos_y   (step_pos_y),
    .res_at_dest (step_at_dest)
  );

  lps_tile_div #(
    .COORD_BITS     (COORD_BITS),
    .STEPS_PER_TILE (STEPS_PER_TILE)
  ) u_div_x (
    .coord (b_pos_x),
    .tile  (div_tile_x)
  );

  lps_tile_div #(
    .COORD_BITS     (COORD_BITS),
    .STEPS_PER_TILE (STEPS_PER_TILE)
  ) u_div_y (
    .coord (b_pos_y),
    .tile  (div_tile_y)
  );

  // Valid flags of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld        <= 1'b0;
      b_vld        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        a_vld <= 1'b1;
      end else if (en_b) begin
        a_vld <= 1'b0;
      end
      if (en_b) begin
        b_vld <= 1'b1;
      end else if (en_c) begin
        b_vld <= 1'b0;
      end
      if (en_c) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_mode  <= mode;
      a_src_x <= src_x;
      a_src_y <= src_y;
      a_dst_x <= dst_x;
      a_dst_y <= dst_y;
    end
    if (en_b) begin
      b_pos_x   <= step_pos_x;
      b_pos_y   <= step_pos_y;
      b_at_dest <= step_at_dest;
    end
    if (en_c) begin
      pos_x          <= b_pos_x;
      pos_y          <= b_pos_y;
      tile_x         <= div_tile_x;
      tile_y         <= div_tile_y;
      at_destination <= b_at_dest;
    end
  end

  // A held step result survives while the output word is stalled.
  `LPS_ASSERT_NEXT(a_step_kept, b_vld && result_valid && result_stall, b_vld, "step result lost under stall")

  // The output empties once its word is taken and nothing follows.
  `LPS_ASSERT_NEXT(a_out_drains, result_valid && !result_stall && !b_vld, !result_valid, "result word repeated")

  // The input side is only held off when the input stage is full and cannot move.
  `LPS_ASSERT_NOW(a_stall_cause, item_stall, a_vld && b_vld && result_valid && result_stall, "input stalled without back pressure")

endmodule
